// ----- hdl/mtt_pkg.sv -----
// Shared constants and types of the multi timer table.
`default_nettype none

package mtt_pkg;

    // Operation codes of an input item.
    localparam logic [1:0] OP_REGISTER = 2'd0;
    localparam logic [1:0] OP_CANCEL   = 2'd1;
    localparam logic [1:0] OP_TICK     = 2'd2;

    // Result kinds.
    localparam logic [2:0] K_REGISTERED = 3'd0;
    localparam logic [2:0] K_FULL       = 3'd1;
    localparam logic [2:0] K_CANCELLED  = 3'd2;
    localparam logic [2:0] K_NOT_FOUND  = 3'd3;
    localparam logic [2:0] K_EXPIRED    = 3'd4;
    localparam logic [2:0] K_TICK_DONE  = 3'd5;

    localparam logic [31:0] MAX_SLEEP_RESET = 32'd10000000;
    localparam logic [15:0] FIRST_ID        = 16'd1;

    // One entry of the slot memory.
    typedef struct packed {
        logic [15:0] id;
        logic [31:0] period;
        logic [31:0] remaining;
        logic        reload;
        logic        notify;
    } t_slot;

endpackage

`default_nettype wire

// ----- hdl/mtt_if.sv -----
// Valid/ready channel interfaces for input items and result items.
`default_nettype none

interface mtt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] interval;
    logic        auto_reload;
    logic        notify;
    logic [15:0] cancel_id;
    logic [31:0] elapsed;

    modport source (output valid, opcode, interval, auto_reload, notify, cancel_id, elapsed,
                    input ready);
    modport sink (input valid, opcode, interval, auto_reload, notify, cancel_id, elapsed,
                  output ready);
endinterface

interface mtt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] id_out;
    logic        notify_out;
    logic [31:0] next_wake;
    logic        last;

    modport source (output valid, kind, id_out, notify_out, next_wake, last, input ready);
    modport sink (input valid, kind, id_out, notify_out, next_wake, last, output ready);
endinterface

`default_nettype wire

// ----- hdl/mtt_slot_mem.sv -----
// Slot memory: one write port and one read port with registered read data.
`default_nettype none

module mtt_slot_mem #(
    parameter  int NUM_TIMERS = 16,
    localparam int AW         = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_re,
    input  wire logic [AW-1:0]        i_raddr,
    output      mtt_pkg::t_slot       o_rdata,
    input  wire logic                 i_we,
    input  wire logic [AW-1:0]        i_waddr,
    input  wire mtt_pkg::t_slot       i_wdata
);
    mtt_pkg::t_slot r_mem [NUM_TIMERS];
    mtt_pkg::t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while no read is issued, so a stalled consumer keeps its entry.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hdl/mtt_seq.sv -----
// Sequencer: decodes items, scans the slot memory and drives the result register.
`default_nettype none

module mtt_seq #(
    parameter  int NUM_TIMERS = 16,
    localparam int AW         = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [31:0]     i_max_sleep,
    mtt_in_if.sink               i_in,
    mtt_out_if.source            o_out,
    output      logic            o_mem_re,
    output      logic [AW-1:0]   o_mem_raddr,
    input  wire mtt_pkg::t_slot  i_mem_rdata,
    output      logic            o_mem_we,
    output      logic [AW-1:0]   o_mem_waddr,
    output      mtt_pkg::t_slot  o_mem_wdata
);
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam logic [CW-1:0] LastCnt = CW'(NUM_TIMERS);

    typedef enum logic [1:0] {S_IDLE, S_REG, S_SCAN} t_state;

    t_state                r_state;
    logic [NUM_TIMERS-1:0] r_valid;
    logic [15:0]           r_next_id;
    logic [1:0]            r_op;
    logic [31:0]           r_interval;
    logic                  r_reload;
    logic                  r_notify;
    logic [15:0]           r_cid;
    logic [31:0]           r_elapsed;
    logic [31:0]           r_wake;
    logic [CW-1:0]         r_iss;
    logic                  r_p_vld;
    logic [AW-1:0]         r_p_addr;
    logic                  r_o_valid;
    logic [2:0]            r_o_kind;
    logic [15:0]           r_o_id;
    logic                  r_o_note;
    logic [31:0]           r_o_wake;
    logic                  r_o_last;

    logic          out_free;
    logic          free_hit;
    logic [AW-1:0] free_idx;
    logic          p_slot_vld;
    logic [32:0]   diff;
    logic          expire;
    logic [31:0]   cand;
    logic          is_tick;
    logic          match;
    logic          need_emit;
    logic          stall;
    logic          issue;
    logic          scan_end;
    logic          o_load;
    logic [15:0]   id_inc;

    assign out_free = !r_o_valid || o_out.ready;

    // Lowest free slot.
    always_comb begin
        free_hit = 1'b0;
        free_idx = '0;
        for (int k = NUM_TIMERS - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_hit = 1'b1;
                free_idx = AW'(k);
            end
        end
    end

    // Processing stage of the scan: the read data belongs to slot r_p_addr.
    assign p_slot_vld = r_p_vld && r_valid[r_p_addr];
    assign diff       = {1'b0, i_mem_rdata.remaining} - {1'b0, r_elapsed};
    assign expire     = diff[32] || (diff[31:0] == 32'd0);
    assign cand       = expire ? i_mem_rdata.period : diff[31:0];
    assign is_tick    = (r_op == mtt_pkg::OP_TICK);
    assign match      = p_slot_vld && (i_mem_rdata.id == r_cid);
    assign need_emit  = is_tick ? (p_slot_vld && expire) : match;
    assign stall      = r_p_vld && need_emit && !out_free;
    assign issue      = (r_state == S_SCAN) && !stall && (r_iss != LastCnt);
    assign scan_end   = (r_iss == LastCnt) && !r_p_vld;
    assign id_inc     = r_next_id + 16'd1;

    // A new result enters the output register in this cycle.
    assign o_load = ((r_state == S_REG) && out_free)
                 || ((r_state == S_SCAN) && !stall && (need_emit || (scan_end && out_free)));

    assign o_mem_re    = issue;
    assign o_mem_raddr = r_iss[AW-1:0];

    always_comb begin
        o_mem_we    = 1'b0;
        o_mem_waddr = r_p_addr;
        o_mem_wdata = i_mem_rdata;
        if (r_state == S_REG) begin
            o_mem_we              = free_hit && out_free;
            o_mem_waddr           = free_idx;
            o_mem_wdata.id        = r_next_id;
            o_mem_wdata.period    = r_interval;
            o_mem_wdata.remaining = r_interval;
            o_mem_wdata.reload    = r_reload;
            o_mem_wdata.notify    = r_notify;
        end else if (r_state == S_SCAN) begin
            // Surviving entries get their new remaining time written back.
            o_mem_we = is_tick && p_slot_vld && !stall && (!expire || i_mem_rdata.reload);
            o_mem_wdata.remaining = cand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_next_id <= mtt_pkg::FIRST_ID;
            r_iss     <= '0;
            r_p_vld   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_load) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op       <= i_in.opcode;
                        r_interval <= i_in.interval;
                        r_reload   <= i_in.auto_reload;
                        r_notify   <= i_in.notify;
                        r_cid      <= i_in.cancel_id;
                        r_elapsed  <= i_in.elapsed;
                        r_wake     <= i_max_sleep;
                        r_iss      <= '0;
                        r_p_vld    <= 1'b0;
                        case (i_in.opcode) inside
                            mtt_pkg::OP_REGISTER:                   r_state <= S_REG;
                            mtt_pkg::OP_CANCEL, mtt_pkg::OP_TICK:   r_state <= S_SCAN;
                            default:                                r_state <= S_IDLE;
                        endcase
                    end
                end
                S_REG: begin
                    if (out_free) begin
                        r_o_note  <= 1'b0;
                        r_o_wake  <= 32'd0;
                        r_o_last  <= 1'b1;
                        if (free_hit) begin
                            r_valid[free_idx] <= 1'b1;
                            r_next_id <= (id_inc == 16'd0) ? mtt_pkg::FIRST_ID : id_inc;
                            r_o_kind  <= mtt_pkg::K_REGISTERED;
                            r_o_id    <= r_next_id;
                        end else begin
                            r_o_kind  <= mtt_pkg::K_FULL;
                            r_o_id    <= 16'd0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (!stall) begin
                        // A cancel that hits ends the scan, so nothing stays in flight.
                        r_p_vld  <= issue && (is_tick || !match);
                        r_p_addr <= r_iss[AW-1:0];
                        if (issue) begin
                            r_iss <= r_iss + CW'(1);
                        end
                        if (is_tick && p_slot_vld) begin
                            if (expire) begin
                                r_o_kind  <= mtt_pkg::K_EXPIRED;
                                r_o_id    <= i_mem_rdata.id;
                                r_o_note  <= i_mem_rdata.notify;
                                r_o_wake  <= 32'd0;
                                r_o_last  <= 1'b0;
                                if (!i_mem_rdata.reload) begin
                                    r_valid[r_p_addr] <= 1'b0;
                                end
                            end
                            if ((!expire || i_mem_rdata.reload) && (cand < r_wake)) begin
                                r_wake <= cand;
                            end
                        end else if (!is_tick && match) begin
                            r_valid[r_p_addr] <= 1'b0;
                            r_o_kind  <= mtt_pkg::K_CANCELLED;
                            r_o_id    <= r_cid;
                            r_o_note  <= 1'b0;
                            r_o_wake  <= 32'd0;
                            r_o_last  <= 1'b1;
                            r_state   <= S_IDLE;
                        end
                        if (scan_end && out_free) begin
                            r_o_kind  <= is_tick ? mtt_pkg::K_TICK_DONE : mtt_pkg::K_NOT_FOUND;
                            r_o_id    <= 16'd0;
                            r_o_note  <= 1'b0;
                            r_o_wake  <= is_tick ? r_wake : 32'd0;
                            r_o_last  <= 1'b1;
                            r_state   <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_o_valid;
    assign o_out.kind       = r_o_kind;
    assign o_out.id_out     = r_o_id;
    assign o_out.notify_out = r_o_note;
    assign o_out.next_wake  = r_o_wake;
    assign o_out.last       = r_o_last;

    a_pstage_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_vld |-> (r_state == S_SCAN))
        else $error("processing stage busy outside a scan");

    a_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_REG |-> (r_next_id != 16'd0))
        else $error("next id is zero");

    a_expired_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_kind == mtt_pkg::K_EXPIRED) |-> !r_o_last)
        else $error("expired result flagged as last");

    a_scan_write_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_mem_we && r_state == S_SCAN) |-> r_valid[r_p_addr])
        else $error("write back to a free slot");

    a_issue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iss <= LastCnt)
        else $error("scan counter past the table");

endmodule

`default_nettype wire

// ----- hdl/multi_timer_table_core.sv -----
// Top level of the multi timer table: configuration register, sequencer and slot memory.
//
// Usage: input items arrive on i_in (valid/ready); an item is taken when both are high.
// Opcode register stores a timer in the lowest free slot and answers with its id or
// with table full. Cancel frees the lowest slot holding the given id or answers not
// found. Tick subtracts the elapsed time from every live slot, emits one expired
// item per expiring slot in slot order, then a tick done item carrying next_wake.
// Opcode 3 is swallowed without a result. Every input's final result has last set.
// A register result is loaded in state S_REG once the output register is free, after
// which the sequencer returns to idle. Cancel and tick walk the slot memory one slot
// per cycle, unless a held result stalls the scan, through its single read port: tick
// done follows the last slot; a cancel that hits slot k answers as slot k is processed.
// The next item is accepted as soon as the previous one has handed its last result
// to the output register, even while that result still waits to be taken.
// A stalled receiver freezes the scan in place; no result is dropped or repeated.
// Reset (i_rst_n low, synchronous) frees all slots, sets the next id to 1 and loads
// max_sleep with 10000000. i_cfg_we writes max_sleep; do so only while idle.
`default_nettype none

module multi_timer_table_core #(
    parameter int NUM_TIMERS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    mtt_in_if.sink           i_in,
    mtt_out_if.source        o_out
);
    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    logic [31:0]    r_max_sleep;
    logic           mem_re;
    logic [AW-1:0]  mem_raddr;
    mtt_pkg::t_slot mem_rdata;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    mtt_pkg::t_slot mem_wdata;

    // The cap on next_wake; sampled when an item is accepted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_sleep <= mtt_pkg::MAX_SLEEP_RESET;
        end else if (i_cfg_we) begin
            r_max_sleep <= i_cfg_wdata;
        end
    end

    mtt_seq #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_sleep (r_max_sleep),
        .i_in        (i_in),
        .o_out       (o_out),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata)
    );

    // Entries are only ever used for slots whose valid bit is set, so the
    // memory needs no clearing.
    mtt_slot_mem #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata)
    );

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench of the multi timer table core with its own table predictor.
`default_nettype none

module tb_top;

    localparam int N_SLOTS = 16;
    // Cycles to let pass after the last result: one full scan plus margin.
    localparam int SETTLE_CYCLES = N_SLOTS + 8;
    // Items of each random phase.
    localparam int PHASE_ITEMS = 46;
    // Watchdog for the whole run, in time units (period 8).
    localparam longint RUN_LIMIT = 64'd400_000_000;
    // The fourth opcode is swallowed by the block without any result.
    localparam logic [1:0] OP_IGNORED = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] interval;
        logic        auto_reload;
        logic        notify;
        logic [15:0] cancel_id;
        logic [31:0] elapsed;
    } t_req;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] id_out;
        logic        notify_out;
        logic [31:0] next_wake;
        logic        last;
    } t_result;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    mtt_in_if  in_ch ();
    mtt_out_if out_ch ();

    multi_timer_table_core #(
        .NUM_TIMERS (N_SLOTS)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Predictor copy of the timer table, the id counter and the wake cap.
    bit          m_live [N_SLOTS];
    logic [15:0] m_tid  [N_SLOTS];
    logic [31:0] m_per  [N_SLOTS];
    logic [31:0] m_left [N_SLOTS];
    bit          m_rel  [N_SLOTS];
    bit          m_ntf  [N_SLOTS];
    logic [15:0] id_next;
    logic [31:0] sleep_cap;

    t_result due_results[$];   // results predicted but not yet seen
    t_req    pend_q[$];        // items waiting for the driver
    t_req    on_bus;           // item currently offered to the block

    int  errors;
    int  n_taken;
    int  n_checked;
    int  n_expired;
    int  n_full;
    bit  in_fire;
    bit  quiet_bus;                  // no gaps on either side while set
    bit  hold_arm;                   // asks the receiver for one long hold-off

    function automatic void add_result(input logic [2:0] kind, input logic [15:0] tid,
                                       input logic ntf, input logic [31:0] wake,
                                       input logic fin);
        t_result r;
        r.kind       = kind;
        r.id_out     = tid;
        r.notify_out = ntf;
        r.next_wake  = wake;
        r.last       = fin;
        due_results.push_back(r);
    endfunction

    // Applies one accepted item to the predicted table and queues what it causes.
    function automatic void timer_table_step(input t_req it);
        logic [31:0] wake;
        bit          hit;
        hit = 1'b0;
        case (it.opcode)
            mtt_pkg::OP_REGISTER: begin
                for (int s = 0; s < N_SLOTS && !hit; s++) begin
                    if (!m_live[s]) begin
                        m_live[s] = 1'b1;
                        m_tid[s]  = id_next;
                        m_per[s]  = it.interval;
                        m_left[s] = it.interval;
                        m_rel[s]  = it.auto_reload;
                        m_ntf[s]  = it.notify;
                        add_result(mtt_pkg::K_REGISTERED, id_next, 1'b0, 32'd0, 1'b1);
                        id_next = id_next + 16'd1;
                        if (id_next == 16'd0) begin
                            id_next = mtt_pkg::FIRST_ID;
                        end
                        hit = 1'b1;
                    end
                end
                // A full table uses up no id.
                if (!hit) begin
                    add_result(mtt_pkg::K_FULL, 16'd0, 1'b0, 32'd0, 1'b1);
                end
            end
            mtt_pkg::OP_CANCEL: begin
                // After the ids wrap, the lowest matching slot is the one freed.
                for (int s = 0; s < N_SLOTS && !hit; s++) begin
                    if (m_live[s] && m_tid[s] == it.cancel_id) begin
                        m_live[s] = 1'b0;
                        add_result(mtt_pkg::K_CANCELLED, it.cancel_id, 1'b0, 32'd0, 1'b1);
                        hit = 1'b1;
                    end
                end
                if (!hit) begin
                    add_result(mtt_pkg::K_NOT_FOUND, 16'd0, 1'b0, 32'd0, 1'b1);
                end
            end
            mtt_pkg::OP_TICK: begin
                wake = sleep_cap;
                for (int s = 0; s < N_SLOTS; s++) begin
                    if (m_live[s]) begin
                        if (m_left[s] <= it.elapsed) begin
                            add_result(mtt_pkg::K_EXPIRED, m_tid[s], m_ntf[s], 32'd0, 1'b0);
                            // A reloaded timer counts with its period, a one-shot
                            // timer is gone and does not count at all.
                            if (m_rel[s]) begin
                                m_left[s] = m_per[s];
                                if (m_left[s] < wake) begin
                                    wake = m_left[s];
                                end
                            end else begin
                                m_live[s] = 1'b0;
                            end
                        end else begin
                            m_left[s] = m_left[s] - it.elapsed;
                            if (m_left[s] < wake) begin
                                wake = m_left[s];
                            end
                        end
                    end
                end
                add_result(mtt_pkg::K_TICK_DONE, 16'd0, 1'b0, wake, 1'b1);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: result %0d, %s expected 0x%0h actual 0x%0h",
                     $time, n_checked, name, want, got);
        end
    endfunction

    // Input acceptance feeds the predictor; result acceptance is checked
    // against the oldest prediction. Both are sampled at the rising edge.
    always @(posedge clk) begin
        t_result want;
        in_fire <= (in_ch.valid === 1'b1) && (in_ch.ready === 1'b1);
        if (rst_n && in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
            timer_table_step(on_bus);
            n_taken++;
        end
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (due_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, actual kind %0d id %0d",
                         $time, out_ch.kind, out_ch.id_out);
            end else begin
                want = due_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(out_ch.kind));
                check_field("id_out", 32'(want.id_out), 32'(out_ch.id_out));
                check_field("notify_out", 32'(want.notify_out), 32'(out_ch.notify_out));
                check_field("next_wake", want.next_wake, out_ch.next_wake);
                check_field("last", 32'(want.last), 32'(out_ch.last));
                if (out_ch.kind == mtt_pkg::K_EXPIRED) begin
                    n_expired++;
                end
                if (out_ch.kind == mtt_pkg::K_FULL) begin
                    n_full++;
                end
            end
            n_checked++;
        end
    end

    // Sender: bursts of items separated by random gaps. An offered item is
    // held until it is taken; a new one is loaded right after a handshake.
    int burst_left;
    int gap_left;

    always @(negedge clk) begin
        if (!in_ch.valid || in_fire) begin
            if (gap_left > 0 && !quiet_bus) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (pend_q.size() > 0) begin
                on_bus = pend_q.pop_front();
                in_ch.opcode      <= on_bus.opcode;
                in_ch.interval    <= on_bus.interval;
                in_ch.auto_reload <= on_bus.auto_reload;
                in_ch.notify      <= on_bus.notify;
                in_ch.cancel_id   <= on_bus.cancel_id;
                in_ch.elapsed     <= on_bus.elapsed;
                in_ch.valid       <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 15);
                    gap_left   = $urandom_range(0, 8);
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: switches between stall patterns; one long hold-off when armed.
    int  hold_left;
    bit  hold_done;
    int  stall_mode;
    int  mode_left;
    int  beat;

    always @(negedge clk) begin
        beat++;
        if (hold_arm && !hold_done) begin
            hold_left = 400;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else if (quiet_bus) begin
            out_ch.ready <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(8, 60);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= 1'($urandom_range(0, 1));
                2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
                default: out_ch.ready <= (beat % 5 != 0);
            endcase
        end
    end

    function automatic t_req make_req(input logic [1:0] op, input logic [31:0] ivl,
                                      input logic rel, input logic ntf,
                                      input logic [15:0] cid, input logic [31:0] el);
        t_req r;
        r.opcode      = op;
        r.interval    = ivl;
        r.auto_reload = rel;
        r.notify      = ntf;
        r.cancel_id   = cid;
        r.elapsed     = el;
        return r;
    endfunction

    function automatic logic [31:0] pick_interval();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            3, 4, 5: return $urandom_range(1, 200);
            default: return $urandom_range(1, 3000);
        endcase
    endfunction

    function automatic logic [31:0] pick_elapsed();
        case ($urandom_range(0, 11))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return $urandom_range(0, 400);
        endcase
    endfunction

    // Mostly live ids, so that cancels hit; otherwise zero, junk or an id
    // that is about to be handed out.
    function automatic logic [15:0] pick_cancel_id();
        int live[$];
        int k;
        k = $urandom_range(0, 9);
        for (int s = 0; s < N_SLOTS; s++) begin
            if (m_live[s]) begin
                live.push_back(s);
            end
        end
        if (k < 7 && live.size() > 0) begin
            return m_tid[live[$urandom_range(0, live.size() - 1)]];
        end
        if (k == 7) begin
            return 16'd0;
        end
        if (k == 8) begin
            return id_next;
        end
        return 16'($urandom);
    endfunction

    function automatic bit bus_idle();
        return pend_q.size() == 0 && !in_ch.valid && due_results.size() == 0;
    endfunction

    // Checked at the rising edge, where the offered item and its predictions agree.
    task automatic wait_idle();
        while (!bus_idle()) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_max_sleep(input logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sleep_cap = value;
    endtask

    initial begin
        #(RUN_LIMIT);
        $display("multi_timer_table_core: mismatch");
        $finish;
    end

    initial begin
        logic [31:0] caps [5];
        t_req        rq;
        int          made;
        int          reg_pct;
        int          roll;
        int          tail;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = 32'd0;
        in_ch.valid       = 1'b0;
        in_ch.opcode      = mtt_pkg::OP_REGISTER;
        in_ch.interval    = 32'd0;
        in_ch.auto_reload = 1'b0;
        in_ch.notify      = 1'b0;
        in_ch.cancel_id   = 16'd0;
        in_ch.elapsed     = 32'd0;
        out_ch.ready      = 1'b0;

        for (int s = 0; s < N_SLOTS; s++) begin
            m_live[s] = 1'b0;
        end
        id_next   = mtt_pkg::FIRST_ID;
        sleep_cap = mtt_pkg::MAX_SLEEP_RESET;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, at the reset value of max_sleep. The table starts
        // empty, so the first tick reports the cap and cancels find nothing.
        @(posedge clk);
        pend_q.push_back(make_req(mtt_pkg::OP_TICK, $urandom, 1'b1, 1'b1, 16'($urandom),
                                  32'd0));
        pend_q.push_back(make_req(mtt_pkg::OP_CANCEL, $urandom, 1'b0, 1'b1, 16'd0, $urandom));
        // Zero interval with reload, all-ones one-shot, zero one-shot, short reload.
        pend_q.push_back(make_req(mtt_pkg::OP_REGISTER, 32'd0, 1'b1, 1'b1, 16'hFFFF,
                                  $urandom));
        pend_q.push_back(make_req(mtt_pkg::OP_REGISTER, 32'hFFFF_FFFF, 1'b0, 1'b0,
                                  16'($urandom), $urandom));
        pend_q.push_back(make_req(mtt_pkg::OP_REGISTER, 32'd0, 1'b0, 1'b1, 16'($urandom),
                                  $urandom));
        pend_q.push_back(make_req(mtt_pkg::OP_REGISTER, 32'd100, 1'b1, 1'b0, 16'($urandom),
                                  $urandom));
        // A tick of zero time still fires the zero-interval timers, and the
        // reloaded one drags next_wake down to zero.
        pend_q.push_back(make_req(mtt_pkg::OP_TICK, $urandom, 1'b0, 1'b0, 16'($urandom),
                                  32'd0));
        pend_q.push_back(make_req(OP_IGNORED, $urandom, 1'b1, 1'b1, 16'($urandom), $urandom));
        // Remaining time exactly equal to the elapsed time expires.
        pend_q.push_back(make_req(mtt_pkg::OP_TICK, $urandom, 1'b1, 1'b0, 16'($urandom),
                                  32'd100));
        pend_q.push_back(make_req(mtt_pkg::OP_CANCEL, $urandom, 1'b1, 1'b1, 16'd1, $urandom));
        pend_q.push_back(make_req(mtt_pkg::OP_TICK, $urandom, 1'b0, 1'b1, 16'($urandom),
                                  32'hFFFF_FFFF));
        // Fill the table, then one register too many.
        repeat (N_SLOTS) begin
            pend_q.push_back(make_req(mtt_pkg::OP_REGISTER, pick_interval(),
                                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                      16'($urandom), $urandom));
        end
        wait_idle();

        // Empty the table with the bus running flat out.
        quiet_bus = 1'b1;
        @(posedge clk);
        for (int s = 0; s < N_SLOTS; s++) begin
            if (m_live[s]) begin
                pend_q.push_back(make_req(mtt_pkg::OP_CANCEL, $urandom, 1'b0, 1'b0, m_tid[s],
                                          $urandom));
            end
        end
        wait_idle();
        quiet_bus = 1'b0;

        // Random phases, each under its own cap; odd phases lean on register
        // so that the table runs full, and phase two holds the receiver off.
        caps[0] = 32'hFFFF_FFFF;
        caps[1] = 32'd1;
        caps[2] = $urandom_range(1, 5000);
        caps[3] = 32'd150;
        caps[4] = mtt_pkg::MAX_SLEEP_RESET;
        for (int p = 0; p < 5; p++) begin
            set_max_sleep(caps[p]);
            reg_pct = (p % 2 == 1) ? 55 : 35;
            made = 0;
            @(posedge clk);
            while (made < PHASE_ITEMS) begin
                while (pend_q.size() >= 2) begin
                    @(negedge clk);
                end
                if (p == 2 && made == 20) begin
                    hold_arm = 1'b1;
                end
                rq = make_req(mtt_pkg::OP_REGISTER, $urandom, 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 16'($urandom), $urandom);
                roll = $urandom_range(0, 99);
                if (roll < reg_pct) begin
                    rq.interval = pick_interval();
                end else if (roll < reg_pct + 25) begin
                    rq.opcode    = mtt_pkg::OP_CANCEL;
                    rq.cancel_id = pick_cancel_id();
                end else if (roll < 97) begin
                    rq.opcode  = mtt_pkg::OP_TICK;
                    rq.elapsed = pick_elapsed();
                end else begin
                    rq.opcode = OP_IGNORED;
                end
                pend_q.push_back(rq);
                if (rq.opcode != OP_IGNORED) begin
                    made++;
                end
            end
            wait_idle();
        end

        // Final drain with a bound of its own, so that a lost result is
        // reported rather than left to the watchdog.
        tail = 0;
        while (!bus_idle() && tail < 20000) begin
            @(posedge clk);
            tail++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (!bus_idle()) begin
            errors++;
            $display("%0t: %0d results still expected at the end, %0d items unsent",
                     $time, due_results.size(), pend_q.size());
        end

        $display("Run covered %0d input items and %0d results under five max_sleep values,",
                 n_taken, n_checked);
        $display("%0d expiries, %0d table-full answers and one long receiver hold-off.",
                 n_expired, n_full);
        if (errors == 0) begin
            $display("multi_timer_table_core: match");
        end else begin
            $display("multi_timer_table_core: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire
